// ===== rtl/mrqj_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrqj_pkg
// Shared types, widths and operation codes for the message ring queue.
// ----------------------------------------------------------------------------
package mrqj_pkg;

  // Default sizing of the queue
  localparam int MAX_SLOTS_DEF = 16;
  localparam int MSG_BITS_DEF  = 32;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;

  // Capacity after reset (clamped to the slot count where instantiated)
  localparam int CAP_RESET = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_RECV = 2'd1;
  localparam logic [OP_W-1:0] OP_JAM  = 2'd2;

  // Per-transaction status from the queue control to the result stage
  typedef struct packed {
    logic              success;
    logic              recv_ok;
    logic [FILL_W-1:0] fill;
  } mrqj_res_t;

endpackage
`default_nettype wire

// ===== rtl/message_ring_queue_with_jam_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// message_ring_queue_with_jam_core
// Circular message queue with send to tail, receive from head and jam at
// head; capacity is a register whose write empties the queue.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_ready  | operation, message
//  out_    | output    | out_valid/out_ready| success, received_message,
//          |           |                    | fill_level
//  cfg_    | input     | cfg_valid/cfg_ready| queue_capacity
//
//  One transaction per cycle while the output is not stalled; a result is
//  registered in the slot RAM read stage, then in the output register, where
//  it raises out_valid. Queue state is updated at the acceptance edge, so
//  back-to-back operations see each other. Reset zeroes head and count and sets
//  capacity to 16 (clamped to MAX_SLOTS); slots are not cleared. A stalled
//  output holds both stages; cfg_ready is always high.
//
module message_ring_queue_with_jam_core
  import mrqj_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int MSG_BITS  = MSG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_W-1:0]    cfg_queue_capacity,
  // Operations
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [MSG_BITS-1:0] in_message,
  // Results
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_success,
  output logic      [MSG_BITS-1:0] out_received_message,
  output logic      [FILL_W-1:0]   out_fill_level
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic              in_accept;
  logic              cfg_we;
  mrqj_res_t         res;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [MSG_BITS-1:0] ram_rdata;

  logic              s1_valid_r, s1_valid_nxt;
  mrqj_res_t         s1_res_r;
  logic              s1_move;
  logic              out_load;

  logic              out_valid_r, out_valid_nxt;
  logic              out_success_r;
  logic [MSG_BITS-1:0] out_msg_r;
  logic [FILL_W-1:0] out_fill_r;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign out_load  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_load;
  assign in_ready  = !s1_valid_r || out_load;
  assign in_accept = in_valid && in_ready;

  // Queue control
  mrqj_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_cap   (cfg_queue_capacity),
    .accept    (in_accept),
    .operation (in_operation),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr)
  );

  // Slot store; read data held while the read stage is stalled
  mrqj_ram #(
    .WIDTH (MSG_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_message),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res_r <= res;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_success_r <= s1_res_r.success;
      out_msg_r     <= s1_res_r.recv_ok ? ram_rdata : '0;
      out_fill_r    <= s1_res_r.fill;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_success          = out_success_r;
  assign out_received_message = out_msg_r;
  assign out_fill_level       = out_fill_r;

endmodule
`default_nettype wire

// ===== rtl/mrqj_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrqj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrqj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/mrqj_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrqj_ctrl
// Head index, fill count and capacity of the ring; decodes each operation,
// steers the slot RAM and reports the status of the transaction.
// ----------------------------------------------------------------------------
module mrqj_ctrl
  import mrqj_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  localparam int IDX_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_cap,
  input  wire logic             accept,
  input  wire logic [OP_W-1:0]  operation,
  output mrqj_res_t             res,
  output logic                  ram_we,
  output logic      [IDX_W-1:0] ram_waddr,
  output logic      [IDX_W-1:0] ram_raddr
);

  localparam int SUM_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
  localparam int LIM_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 2;
  localparam logic [LIM_W-1:0] MAX_SLOTS_L = LIM_W'(MAX_SLOTS);
  localparam int CAP_RST_I = (CAP_RESET > MAX_SLOTS) ? MAX_SLOTS : CAP_RESET;

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;

  logic [SUM_W-1:0]  head_x, count_x, cap_x;
  logic [SUM_W-1:0]  tail_sum, jam_sum, inc_sum;
  logic [IDX_W-1:0]  tail_idx, jam_idx, inc_idx;
  logic              not_full, not_empty;
  logic [LIM_W-1:0]  cfg_x;
  logic [CAP_W-1:0]  cap_lim;

  // Ring index arithmetic: each wrap is one conditional subtract
  always_comb begin
    head_x   = SUM_W'(head_r);
    count_x  = SUM_W'(count_r);
    cap_x    = SUM_W'(cap_r);
    tail_sum = head_x + count_x;
    if (tail_sum >= cap_x) begin
      tail_sum = tail_sum - cap_x;
    end
    jam_sum = head_x + cap_x - SUM_W'(1);
    if (jam_sum >= cap_x) begin
      jam_sum = jam_sum - cap_x;
    end
    inc_sum = head_x + SUM_W'(1);
    if (inc_sum >= cap_x) begin
      inc_sum = inc_sum - cap_x;
    end
    tail_idx  = tail_sum[IDX_W-1:0];
    jam_idx   = jam_sum[IDX_W-1:0];
    inc_idx   = inc_sum[IDX_W-1:0];
    not_full  = (count_x < cap_x);
    not_empty = (count_r != '0);
  end

  // Clamp a capacity write to 1..MAX_SLOTS
  always_comb begin
    cfg_x = LIM_W'(cfg_cap);
    if (cfg_cap == '0) begin
      cap_lim = CAP_W'(1);
    end else if (cfg_x > MAX_SLOTS_L) begin
      cap_lim = CAP_W'(MAX_SLOTS);
    end else begin
      cap_lim = cfg_cap;
    end
  end

  // Operation decode and next state
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    ram_we      = 1'b0;
    ram_waddr   = tail_idx;
    ram_raddr   = head_r;
    res.success = 1'b0;
    res.recv_ok = 1'b0;
    if (cfg_we) begin
      cap_nxt   = cap_lim;
      head_nxt  = '0;
      count_nxt = '0;
    end else if (accept) begin
      case (operation)
        OP_SEND: begin
          if (not_full) begin
            ram_we      = 1'b1;
            count_nxt   = count_r + FILL_W'(1);
            res.success = 1'b1;
          end
        end
        OP_RECV: begin
          if (not_empty) begin
            head_nxt    = inc_idx;
            count_nxt   = count_r - FILL_W'(1);
            res.success = 1'b1;
            res.recv_ok = 1'b1;
          end
        end
        OP_JAM: begin
          if (not_full) begin
            ram_we      = 1'b1;
            ram_waddr   = jam_idx;
            head_nxt    = jam_idx;
            count_nxt   = count_r + FILL_W'(1);
            res.success = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.fill = count_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      cap_r   <= CAP_W'(CAP_RST_I);
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

endmodule
`default_nettype wire
